FILE: rtl/core/srs_pkg.sv
// ----------------------------------------------------------------------------
// srs_pkg
// Shared constants, codes and types of the rotating sprite sampler.
// ----------------------------------------------------------------------------
package srs_pkg;

  localparam int SRS_SRC_W_MAX     = 64;
  localparam int SRS_SRC_H_MAX     = 16;
  localparam int SRS_BOX_MAX       = 64;
  localparam int SRS_COLOR_BITS    = 4;
  localparam int SRS_QUEUE_DEPTH   = 8;
  localparam int SRS_KIND_BITS     = 2;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [2:0] CFG_COS    = 3'd0;
  localparam logic [2:0] CFG_SIN    = 3'd1;
  localparam logic [2:0] CFG_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_BOX    = 3'd4;

  typedef enum logic [SRS_KIND_BITS-1:0] {
    KIND_LOAD,
    KIND_BLANK,
    KIND_PROBE
  } srs_kind_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_CHK0,
    BK_CHK1,
    BK_CHK2
  } srs_bk_state_t;

  typedef struct packed {
    logic [15:0] cos_coeff;
    logic [15:0] sin_coeff;
    logic [6:0]  src_width;
    logic [4:0]  src_height;
    logic [6:0]  box_size;
  } srs_cfg_t;

  // queue entry: kind, three in-range flags, color, three addresses
  function automatic int srs_entry_bits(input int cb, input int aw);
    return SRS_KIND_BITS + 3 + cb + 3 * aw;
  endfunction

endpackage

FILE: rtl/core/sprite_rotate_sampler.sv
// ----------------------------------------------------------------------------
// sprite_rotate_sampler
// Nearest-neighbour rotating sampler over a small sprite of palette indices.
// Items enter on start/busy: taken at a rising edge with start high and busy
// low. A load item in range writes one texel and gives no result; a sample
// item gives exactly one pixel_color, shown for one cycle with out_strobe
// high. The receiver cannot stall, so results are never held back.
// Path: a sample passes the two front pipe stages and the queue and, inside
// the box, up to three reads of the single-port sprite store before its
// strobe rises.
// Throughput: one store read per probed texel; the front takes one item per
// cycle until the queue and the front pipe together hold the queue depth,
// then busy rises.
// Reset: synchronous, rst_n low. The registers take their reset values and
// the store is then cleared one entry a cycle, all SRC_W_MAX * SRC_H_MAX
// entries (1024 by default), with busy high. cfg writes must come only
// while no item is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module sprite_rotate_sampler #(
  parameter int SRC_W_MAX  = srs_pkg::SRS_SRC_W_MAX,
  parameter int SRC_H_MAX  = srs_pkg::SRS_SRC_H_MAX,
  parameter int BOX_MAX    = srs_pkg::SRS_BOX_MAX,
  parameter int COLOR_BITS = srs_pkg::SRS_COLOR_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [5:0]  in_pos_x,
  input  logic [5:0]  in_pos_y,
  input  logic [3:0]  in_texel_color,
  output logic        out_strobe,
  output logic [3:0]  out_pixel_color,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import srs_pkg::*;

  localparam int AW    = $clog2(SRC_W_MAX * SRC_H_MAX);
  localparam int EW    = srs_entry_bits(COLOR_BITS, AW);
  localparam int QD    = SRS_QUEUE_DEPTH;
  localparam int LW    = $clog2(QD + 1);
  localparam int SW    = LW + 1;

  srs_cfg_t      cfg_r;
  logic          take;
  logic          push;
  logic [EW-1:0] push_data;
  logic [1:0]    pend;
  logic          q_pop;
  logic          q_empty;
  logic [LW-1:0] q_level;
  logic [EW-1:0] q_head;
  logic          clearing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cos_coeff  <= 16'sd16384;
      cfg_r.sin_coeff  <= 16'd0;
      cfg_r.src_width  <= 7'd46;
      cfg_r.src_height <= 5'd8;
      cfg_r.box_size   <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COS:    cfg_r.cos_coeff  <= cfg_data;
        CFG_SIN:    cfg_r.sin_coeff  <= cfg_data;
        CFG_WIDTH:  cfg_r.src_width  <= cfg_data[6:0];
        CFG_HEIGHT: cfg_r.src_height <= cfg_data[4:0];
        CFG_BOX:    cfg_r.box_size   <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // hold off while clearing or if the queue cannot take all the front pipe
  assign busy = clearing || ((SW'(q_level) + SW'(pend)) >= SW'(QD));
  assign take = start && !busy;

  srs_front #(
    .SRC_W_MAX  (SRC_W_MAX),
    .SRC_H_MAX  (SRC_H_MAX),
    .BOX_MAX    (BOX_MAX),
    .COLOR_BITS (COLOR_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .take           (take),
    .in_operation   (in_operation),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_texel_color (in_texel_color),
    .push           (push),
    .push_data      (push_data),
    .pend           (pend)
  );

  srs_queue #(
    .DW    (EW),
    .DEPTH (QD)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .empty     (q_empty),
    .level     (q_level),
    .head      (q_head)
  );

  srs_back #(
    .SRC_W_MAX  (SRC_W_MAX),
    .SRC_H_MAX  (SRC_H_MAX),
    .COLOR_BITS (COLOR_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_data          (q_head),
    .q_pop           (q_pop),
    .clearing        (clearing),
    .out_strobe      (out_strobe),
    .out_pixel_color (out_pixel_color)
  );

endmodule

FILE: rtl/core/srs_front.sv
// ----------------------------------------------------------------------------
// srs_front
// Accepts items, rotates sample coordinates and builds queue entries.
// ----------------------------------------------------------------------------
module srs_front #(
  parameter int SRC_W_MAX  = srs_pkg::SRS_SRC_W_MAX,
  parameter int SRC_H_MAX  = srs_pkg::SRS_SRC_H_MAX,
  parameter int BOX_MAX    = srs_pkg::SRS_BOX_MAX,
  parameter int COLOR_BITS = srs_pkg::SRS_COLOR_BITS,
  localparam int AW = $clog2(SRC_W_MAX * SRC_H_MAX),
  localparam int EW = srs_pkg::srs_entry_bits(COLOR_BITS, AW)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  srs_pkg::srs_cfg_t  cfg,
  input  logic               take,
  input  logic               in_operation,
  input  logic [5:0]         in_pos_x,
  input  logic [5:0]         in_pos_y,
  input  logic [3:0]         in_texel_color,
  output logic               push,
  output logic [EW-1:0]      push_data,
  output logic [1:0]         pend
);
  import srs_pkg::*;

  typedef struct packed {
    srs_kind_t               kind;
    logic [2:0]              ok;
    logic [COLOR_BITS-1:0]   color;
    logic [AW-1:0]           addr2;
    logic [AW-1:0]           addr1;
    logic [AW-1:0]           addr0;
  } ent_t;

  localparam logic [AW-1:0] W_C = AW'(SRC_W_MAX);

  function automatic logic x_ok(input logic signed [13:0] x, input logic [13:0] lim);
    return !x[13] && ($unsigned(x) < lim);
  endfunction

  function automatic logic [AW-1:0] map_addr(input logic signed [13:0] x,
                                             input logic signed [13:0] y);
    return AW'(y) * W_C + AW'(x);
  endfunction

  logic [13:0]            w_lim;
  logic [13:0]            h_lim;
  logic [8:0]             b_lim;
  logic                   is_sample;
  logic                   ld_ok;
  logic                   in_box;
  logic signed [8:0]      dx2;
  logic signed [8:0]      dy2;

  logic                   s1_v_r;
  logic                   s1_v_nxt;
  srs_kind_t              s1_kind_r;
  srs_kind_t              s1_kind_nxt;
  logic signed [24:0]     s1_pcx_r;
  logic signed [24:0]     s1_psy_r;
  logic signed [24:0]     s1_psx_r;
  logic signed [24:0]     s1_pcy_r;
  logic [AW-1:0]          s1_addr_r;
  logic [COLOR_BITS-1:0]  s1_color_r;

  logic signed [27:0]     sx;
  logic signed [27:0]     sy;

  logic                   s2_v_r;
  srs_kind_t              s2_kind_r;
  logic signed [12:0]     s2_ix_r;
  logic signed [12:0]     s2_iy_r;
  logic [AW-1:0]          s2_addr_r;
  logic [COLOR_BITS-1:0]  s2_color_r;

  logic signed [13:0]     xa;
  logic signed [13:0]     xb;
  logic signed [13:0]     ya;
  logic signed [13:0]     yb;
  ent_t                   ent;

  // effective sizes
  always_comb begin
    w_lim = ({7'd0, cfg.src_width} > 14'(SRC_W_MAX)) ? 14'(SRC_W_MAX)
                                                      : {7'd0, cfg.src_width};
    h_lim = ({9'd0, cfg.src_height} > 14'(SRC_H_MAX)) ? 14'(SRC_H_MAX)
                                                       : {9'd0, cfg.src_height};
    b_lim = ({2'd0, cfg.box_size} > 9'(BOX_MAX)) ? 9'(BOX_MAX) : {2'd0, cfg.box_size};
  end

  // stage 1: classify and multiply
  always_comb begin
    is_sample   = (in_operation == OP_SAMPLE);
    ld_ok       = (14'(in_pos_x) < w_lim) && (14'(in_pos_y) < h_lim);
    in_box      = (9'(in_pos_x) < b_lim) && (9'(in_pos_y) < b_lim);
    dx2         = $signed({2'b00, in_pos_x, 1'b1}) - $signed({2'b00, cfg.box_size});
    dy2         = $signed({2'b00, in_pos_y, 1'b1}) - $signed({2'b00, cfg.box_size});
    s1_v_nxt    = take && (is_sample || ld_ok);
    if (!is_sample) begin
      s1_kind_nxt = KIND_LOAD;
    end else if (in_box) begin
      s1_kind_nxt = KIND_PROBE;
    end else begin
      s1_kind_nxt = KIND_BLANK;
    end
  end

  // stage 2: sum and floor
  always_comb begin
    sx = $signed({7'd0, cfg.src_width, 14'd0}) + 28'(s1_pcx_r) + 28'(s1_psy_r);
    sy = $signed({9'd0, cfg.src_height, 14'd0}) - 28'(s1_psx_r) + 28'(s1_pcy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_kind_r  <= s1_kind_nxt;
    s1_pcx_r   <= $signed(cfg.cos_coeff) * dx2;
    s1_psy_r   <= $signed(cfg.sin_coeff) * dy2;
    s1_psx_r   <= $signed(cfg.sin_coeff) * dx2;
    s1_pcy_r   <= $signed(cfg.cos_coeff) * dy2;
    s1_addr_r  <= map_addr(14'(in_pos_x), 14'(in_pos_y));
    s1_color_r <= COLOR_BITS'(in_texel_color);
    s2_kind_r  <= s1_kind_r;
    s2_ix_r    <= sx[27:15];
    s2_iy_r    <= sy[27:15];
    s2_addr_r  <= s1_addr_r;
    s2_color_r <= s1_color_r;
  end

  // stage 3: neighbour range checks and addresses
  always_comb begin
    xa        = 14'(s2_ix_r);
    ya        = 14'(s2_iy_r);
    xb        = xa + 14'sd1;
    yb        = ya + 14'sd1;
    ent.kind  = s2_kind_r;
    ent.color = s2_color_r;
    if (s2_kind_r == KIND_LOAD) begin
      ent.ok    = 3'b000;
      ent.addr0 = s2_addr_r;
      ent.addr1 = s2_addr_r;
      ent.addr2 = s2_addr_r;
    end else begin
      ent.ok[0] = x_ok(xa, w_lim) && x_ok(ya, h_lim);
      ent.ok[1] = x_ok(xb, w_lim) && x_ok(ya, h_lim);
      ent.ok[2] = x_ok(xa, w_lim) && x_ok(yb, h_lim);
      ent.addr0 = map_addr(xa, ya);
      ent.addr1 = map_addr(xb, ya);
      ent.addr2 = map_addr(xa, yb);
    end
  end

  assign push      = s2_v_r;
  assign push_data = ent;
  assign pend      = {1'b0, s1_v_r} + {1'b0, s2_v_r};

endmodule

FILE: rtl/core/srs_queue.sv
// ----------------------------------------------------------------------------
// srs_queue
// Small register queue between the front and back parts.
// ----------------------------------------------------------------------------
module srs_queue #(
  parameter int DW    = 8,
  parameter int DEPTH = srs_pkg::SRS_QUEUE_DEPTH,
  localparam int PW = $clog2(DEPTH),
  localparam int LW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  input  logic          pop,
  output logic          empty,
  output logic [LW-1:0] level,
  output logic [DW-1:0] head
);
  import srs_pkg::*;

  logic [DW-1:0] slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r;
  logic [PW-1:0] rd_ptr_nxt;
  logic [LW-1:0] count_r;
  logic [LW-1:0] count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign empty = (count_r == '0);
  assign level = count_r;
  assign head  = slot_r[rd_ptr_r];

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != LW'(DEPTH)))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LW'(DEPTH))
    else $error("queue count out of bound");
`endif

endmodule

FILE: rtl/core/srs_back.sv
// ----------------------------------------------------------------------------
// srs_back
// Owns the sprite store: clears it, performs loads and probe reads.
// ----------------------------------------------------------------------------
module srs_back #(
  parameter int SRC_W_MAX  = srs_pkg::SRS_SRC_W_MAX,
  parameter int SRC_H_MAX  = srs_pkg::SRS_SRC_H_MAX,
  parameter int COLOR_BITS = srs_pkg::SRS_COLOR_BITS,
  localparam int DEPTH = SRC_W_MAX * SRC_H_MAX,
  localparam int AW    = $clog2(DEPTH),
  localparam int EW    = srs_pkg::srs_entry_bits(COLOR_BITS, AW)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  logic [EW-1:0] q_data,
  output logic          q_pop,
  output logic          clearing,
  output logic          out_strobe,
  output logic [3:0]    out_pixel_color
);
  import srs_pkg::*;

  typedef struct packed {
    srs_kind_t               kind;
    logic [2:0]              ok;
    logic [COLOR_BITS-1:0]   color;
    logic [AW-1:0]           addr2;
    logic [AW-1:0]           addr1;
    logic [AW-1:0]           addr0;
  } ent_t;

  logic [COLOR_BITS-1:0] mem [DEPTH];
  logic [COLOR_BITS-1:0] rdata_r;

  srs_bk_state_t         state_r;
  srs_bk_state_t         state_nxt;
  logic [AW-1:0]         clr_r;
  logic [AW-1:0]         clr_nxt;
  ent_t                  head;
  ent_t                  ent_r;
  logic                  ent_ld;
  logic                  okcur_r;
  logic                  okcur_nxt;
  logic                  out_strobe_r;
  logic                  out_strobe_nxt;
  logic [3:0]            out_pixel_r;
  logic [3:0]            out_pixel_nxt;
  logic                  mem_we;
  logic [AW-1:0]         mem_addr;
  logic [COLOR_BITS-1:0] mem_wdata;
  logic [COLOR_BITS-1:0] probe_d;

  assign head    = q_data;
  assign probe_d = okcur_r ? rdata_r : '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: begin
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!q_empty && head.kind == KIND_PROBE) begin
          state_nxt = BK_CHK0;
        end
      end
      BK_CHK0: begin
        state_nxt = (probe_d != '0) ? BK_IDLE : BK_CHK1;
      end
      BK_CHK1: begin
        state_nxt = (probe_d != '0) ? BK_IDLE : BK_CHK2;
      end
      BK_CHK2: begin
        state_nxt = BK_IDLE;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    mem_we         = 1'b0;
    mem_addr       = '0;
    mem_wdata      = '0;
    q_pop          = 1'b0;
    out_strobe_nxt = 1'b0;
    out_pixel_nxt  = out_pixel_r;
    okcur_nxt      = okcur_r;
    ent_ld         = 1'b0;
    clr_nxt        = clr_r;
    case (state_r)
      BK_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_r;
        clr_nxt  = clr_r + 1'b1;
      end
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (head.kind)
            KIND_LOAD: begin
              mem_we    = 1'b1;
              mem_addr  = head.addr0;
              mem_wdata = head.color;
            end
            KIND_BLANK: begin
              out_strobe_nxt = 1'b1;
              out_pixel_nxt  = '0;
            end
            KIND_PROBE: begin
              mem_addr  = head.addr0;
              okcur_nxt = head.ok[0];
              ent_ld    = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      BK_CHK0: begin
        if (probe_d != '0) begin
          out_strobe_nxt = 1'b1;
          out_pixel_nxt  = 4'(probe_d);
        end else begin
          mem_addr  = ent_r.addr1;
          okcur_nxt = ent_r.ok[1];
        end
      end
      BK_CHK1: begin
        if (probe_d != '0) begin
          out_strobe_nxt = 1'b1;
          out_pixel_nxt  = 4'(probe_d);
        end else begin
          mem_addr  = ent_r.addr2;
          okcur_nxt = ent_r.ok[2];
        end
      end
      BK_CHK2: begin
        out_strobe_nxt = 1'b1;
        out_pixel_nxt  = 4'(probe_d);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_CLEAR;
      clr_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    okcur_r     <= okcur_nxt;
    out_pixel_r <= out_pixel_nxt;
    if (ent_ld) begin
      ent_r <= head;
    end
  end

  // single-port sprite store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_r <= mem[mem_addr];
  end

  assign clearing        = (state_r == BK_CLEAR);
  assign out_strobe      = out_strobe_r;
  assign out_pixel_color = out_pixel_r;

`ifndef SYNTH
  a_clear_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_CLEAR) |-> !q_pop)
    else $error("queue popped during clear");
  a_probe_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_CHK0 || state_r == BK_CHK1 || state_r == BK_CHK2) |-> !mem_we)
    else $error("store written during probe");
  a_clear_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_CLEAR) |=> !out_strobe_r)
    else $error("result during clear");
`endif

endmodule
